// File: hdl/fsd_pkg.sv
// Shared types and constants for the Floyd-Steinberg grayscale ditherer.
package fsd_pkg;

  localparam int PIX_W       = 8;
  localparam int ROW_WIDTH_W = 13;
  localparam int LEVEL_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  // Radix-4 quantizer: four steps give the eight quotient bits.
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_MUL,
    S_ERR,
    S_OUT
  } fsd_state_t;

endpackage

// File: hdl/fsd_in_if.sv
// Valid/ready channel that carries one input pixel beat.
interface fsd_in_if;
  logic                      valid;
  logic                      ready;
  logic [fsd_pkg::PIX_W-1:0] gray_in;
  logic [fsd_pkg::PIX_W-1:0] alpha_in;
  logic                      frame_start;

  modport source (output valid, output gray_in, output alpha_in, output frame_start,
                  input ready);
  modport sink   (input valid, input gray_in, input alpha_in, input frame_start,
                  output ready);
endinterface

// File: hdl/fsd_out_if.sv
// Valid/ready channel that carries one dithered pixel beat.
interface fsd_out_if;
  logic                      valid;
  logic                      ready;
  logic [fsd_pkg::PIX_W-1:0] gray_out;
  logic [fsd_pkg::PIX_W-1:0] alpha_out;

  modport source (output valid, output gray_out, output alpha_out, input ready);
  modport sink   (input valid, input gray_out, input alpha_out, output ready);
endinterface

// File: hdl/fsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fsd_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/floyd_steinberg_dither_gray.sv
// Top level of the Floyd-Steinberg error-diffusion ditherer for gray pixels.
//
//   Channel   Direction  Handshake              Beat contents
//   in_pix    sink       valid/ready            gray_in, alpha_in, frame_start
//   out_pix   source     valid/ready            gray_out, alpha_out
//   cfg_*     sink       cfg_we (no wait)       cfg_idx, cfg_data
//
// A pixel passes through these steps when the output side keeps up: the
// accept, a read of the line store with the error sum, four radix-4 steps
// of the quantizer divider, a multiply, an error spread and a load of the
// output register. A new pixel is taken only once the last one has been
// loaded into the output register. Reset is synchronous and needs no
// clearing pass, since line store data is ignored on the first row.
// A stalled output holds the block in its last state until the result is taken.
module floyd_steinberg_dither_gray #(
  parameter int MAX_ROW_WIDTH = 4096,
  parameter int ERROR_BITS    = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fsd_in_if.sink                            in_pix,
  fsd_out_if.source                         out_pix,
  input  logic                              cfg_we,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Column index width, and the width used to compare a column with the row width.
  localparam int CW   = $clog2(MAX_ROW_WIDTH);
  localparam int CMPW = (CW + 1 > fsd_pkg::ROW_WIDTH_W) ? CW + 1 : fsd_pkg::ROW_WIDTH_W;
  // Error widths: stored errors, the working sum, the spread products and their sums.
  localparam int E    = ERROR_BITS;
  localparam int AW   = ERROR_BITS + 2;
  localparam int PW   = AW + 3;
  localparam int SW   = PW + 1;

  localparam logic signed [SW-1:0] ERR_HI = SW'(2 ** (ERROR_BITS - 1) - 1);
  localparam logic signed [SW-1:0] ERR_LO = SW'(-(2 ** (ERROR_BITS - 1)));
  localparam logic [CMPW-1:0]      WIDTH_MAX = CMPW'(MAX_ROW_WIDTH);

  // Saturate a wide signed sum into a stored error.
  function automatic logic signed [E-1:0] sat_e(input logic signed [SW-1:0] v);
    logic signed [E-1:0] r;
    if (v > ERR_HI) begin
      r = ERR_HI[E-1:0];
    end else if (v < ERR_LO) begin
      r = ERR_LO[E-1:0];
    end else begin
      r = v[E-1:0];
    end
    return r;
  endfunction

  // Divide by sixteen, truncating toward zero.
  function automatic logic signed [PW-1:0] div16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] b;
    b = p + (p[PW-1] ? PW'(15) : PW'(0));
    return b >>> 4;
  endfunction

  // Configuration registers.
  logic [fsd_pkg::ROW_WIDTH_W-1:0] row_width_r;
  logic [fsd_pkg::LEVEL_W-1:0]     interval_len_r;
  logic                            has_alpha_r;

  // Sequencer and frame tracking.
  fsd_pkg::fsd_state_t state_r, state_nxt;
  logic [CW-1:0]       column_index_r, column_index_nxt;
  logic                on_first_row_r, on_first_row_nxt;
  logic signed [E-1:0] carry_r, carry_nxt;
  logic signed [E-1:0] pend_cur_r, pend_cur_nxt;
  logic signed [E-1:0] pend_prev_r, pend_prev_nxt;

  // Per-pixel working registers.
  logic [CW-1:0]                   col_r, col_nxt;
  logic                            first_r, first_nxt;
  logic                            last_r, last_nxt;
  logic [fsd_pkg::PIX_W-1:0]       gray_r, gray_nxt;
  logic [fsd_pkg::PIX_W-1:0]       alpha_r, alpha_nxt;
  logic signed [AW-1:0]            acc_r, acc_nxt;
  logic [8:0]                      rem_r, rem_nxt;
  logic [8:0]                      dsr_r, dsr_nxt;
  logic [7:0]                      dvd_r, dvd_nxt;
  logic [7:0]                      quo_r, quo_nxt;
  logic [fsd_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fsd_pkg::PIX_W-1:0]       q_r, q_nxt;
  logic signed [AW-1:0]            err_r, err_nxt;
  logic signed [E-1:0]             wlast_r, wlast_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [fsd_pkg::PIX_W-1:0]       out_gray_r, out_gray_nxt;
  logic [fsd_pkg::PIX_W-1:0]       out_alpha_r, out_alpha_nxt;

  // Line store port signals.
  logic                ram_we;
  logic [CW-1:0]       ram_waddr;
  logic [E-1:0]        ram_wdata;
  logic                ram_re;
  logic [CW-1:0]       ram_raddr;
  logic [E-1:0]        ram_rdata;
  logic signed [E-1:0] rd_err;

  // Combinational helpers.
  logic                            in_beat;
  logic [fsd_pkg::LEVEL_W-1:0]     lvl;
  logic [7:0]                      clamp_v;
  logic [9:0]                      dividend;
  logic [CMPW-1:0]                 colp1;
  logic [CMPW-1:0]                 weff;
  logic [8:0]                      rem_in;
  logic [7:0]                      dvd_in;
  logic [10:0]                     t_div, d1, d2, d3, r_div;
  logic [1:0]                      qd;
  logic [15:0]                     prod;
  logic [fsd_pkg::PIX_W-1:0]       q_sat;
  logic signed [PW-1:0]            err_x, e7, e3, e5, e1;

  assign in_beat = in_pix.valid && in_pix.ready;
  assign in_pix.ready = (state_r == fsd_pkg::S_IDLE);
  assign rd_err = ram_rdata;

  // An interval of zero acts as one.
  assign lvl = (interval_len_r == '0) ? fsd_pkg::LEVEL_W'(1) : interval_len_r;

  fsd_ram #(
    .WIDTH (ERROR_BITS),
    .DEPTH (MAX_ROW_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= fsd_pkg::ROW_WIDTH_W'(512);
      interval_len_r <= fsd_pkg::LEVEL_W'(255);
      has_alpha_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        fsd_pkg::REG_ROW_WIDTH:    row_width_r    <= cfg_data[fsd_pkg::ROW_WIDTH_W-1:0];
        fsd_pkg::REG_INTERVAL_LEN: interval_len_r <= cfg_data[fsd_pkg::LEVEL_W-1:0];
        fsd_pkg::REG_HAS_ALPHA:    has_alpha_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state and datapath.
  always_comb begin
    state_nxt        = state_r;
    column_index_nxt = column_index_r;
    on_first_row_nxt = on_first_row_r;
    carry_nxt        = carry_r;
    pend_cur_nxt     = pend_cur_r;
    pend_prev_nxt    = pend_prev_r;
    col_nxt          = col_r;
    first_nxt        = first_r;
    last_nxt         = last_r;
    gray_nxt         = gray_r;
    alpha_nxt        = alpha_r;
    acc_nxt          = acc_r;
    rem_nxt          = rem_r;
    dsr_nxt          = dsr_r;
    dvd_nxt          = dvd_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    q_nxt            = q_r;
    err_nxt          = err_r;
    wlast_nxt        = wlast_r;
    out_valid_nxt    = out_valid_r;
    out_gray_nxt     = out_gray_r;
    out_alpha_nxt    = out_alpha_r;

    ram_we    = 1'b0;
    ram_waddr = col_r;
    ram_wdata = '0;
    ram_re    = in_beat;
    ram_raddr = in_pix.frame_start ? '0 : column_index_r;

    // Clamp the working value and form the rounding dividend 2c + l over divisor 2l.
    if (acc_r[AW-1]) begin
      clamp_v = '0;
    end else if (acc_r > AW'(255)) begin
      clamp_v = 8'd255;
    end else begin
      clamp_v = acc_r[7:0];
    end
    dividend = {1'b0, clamp_v, 1'b0} + {2'b00, lvl};

    // Effective row width: zero acts as one, anything past the store acts as its depth.
    colp1 = CMPW'(col_r) + CMPW'(1);
    weff  = CMPW'(row_width_r);
    if (weff == '0) begin
      weff = CMPW'(1);
    end
    if (weff > WIDTH_MAX) begin
      weff = WIDTH_MAX;
    end

    // The first step takes its operands straight from the registered working sum:
    // the top two dividend bits seed the remainder. Later steps take the shifted
    // remainder and dividend from their registers.
    if (state_r == fsd_pkg::S_DIV && cnt_r == '0) begin
      rem_in = {7'd0, dividend[9:8]};
      dvd_in = dividend[7:0];
    end else begin
      rem_in = rem_r;
      dvd_in = dvd_r;
    end

    // One radix-4 restoring division step.
    t_div = {rem_in, dvd_in[7:6]};
    d1    = {2'b00, dsr_r};
    d2    = {1'b0, dsr_r, 1'b0};
    d3    = d1 + d2;
    if (t_div >= d3) begin
      qd    = 2'd3;
      r_div = t_div - d3;
    end else if (t_div >= d2) begin
      qd    = 2'd2;
      r_div = t_div - d2;
    end else if (t_div >= d1) begin
      qd    = 2'd1;
      r_div = t_div - d1;
    end else begin
      qd    = 2'd0;
      r_div = t_div;
    end

    // Level index times interval, saturated to the pixel range.
    prod  = quo_r * lvl;
    q_sat = (prod > 16'd255) ? 8'd255 : prod[7:0];

    // Error spread with weights 7, 3, 5 and 1 sixteenths.
    err_x = PW'(err_r);
    e7    = div16((err_x <<< 3) - err_x);
    e3    = div16((err_x <<< 1) + err_x);
    e5    = div16((err_x <<< 2) + err_x);
    e1    = div16(err_x);

    case (state_r)
      fsd_pkg::S_IDLE: begin
        if (in_beat) begin
          gray_nxt  = in_pix.gray_in;
          alpha_nxt = has_alpha_r ? in_pix.alpha_in : '0;
          if (in_pix.frame_start) begin
            col_nxt          = '0;
            first_nxt        = 1'b1;
            column_index_nxt = '0;
            on_first_row_nxt = 1'b1;
            carry_nxt        = '0;
            pend_cur_nxt     = '0;
            pend_prev_nxt    = '0;
          end else begin
            col_nxt   = column_index_r;
            first_nxt = on_first_row_r;
          end
          state_nxt = fsd_pkg::S_ACC;
        end
      end
      fsd_pkg::S_ACC: begin
        acc_nxt = AW'($signed({1'b0, gray_r})) + AW'(carry_r) +
                  (first_r ? AW'(0) : AW'(rd_err));
        last_nxt  = (colp1 >= weff);
        state_nxt = fsd_pkg::S_DIV;
        cnt_nxt   = '0;
        quo_nxt   = '0;
      end
      fsd_pkg::S_DIV: begin
        // Each pass retires one radix-4 quotient digit.
        rem_nxt = r_div[8:0];
        dvd_nxt = {dvd_in[5:0], 2'b00};
        quo_nxt = {quo_r[5:0], qd};
        cnt_nxt = cnt_r + fsd_pkg::DIV_CNT_W'(1);
        if (cnt_r == fsd_pkg::DIV_CNT_W'(fsd_pkg::DIV_STEPS - 1)) begin
          state_nxt = fsd_pkg::S_MUL;
        end
      end
      fsd_pkg::S_MUL: begin
        q_nxt     = q_sat;
        err_nxt   = acc_r - AW'($signed({1'b0, q_sat}));
        state_nxt = fsd_pkg::S_ERR;
      end
      fsd_pkg::S_ERR: begin
        if (col_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = col_r - CW'(1);
          ram_wdata = sat_e(SW'(pend_prev_r) + SW'(e3));
        end
        if (last_r) begin
          wlast_nxt        = sat_e(SW'(pend_cur_r) + SW'(e5));
          carry_nxt        = '0;
          pend_prev_nxt    = '0;
          pend_cur_nxt     = '0;
          column_index_nxt = '0;
          on_first_row_nxt = 1'b0;
        end else begin
          pend_prev_nxt    = sat_e(SW'(pend_cur_r) + SW'(e5));
          pend_cur_nxt     = sat_e(SW'(e1));
          carry_nxt        = sat_e(SW'(e7));
          column_index_nxt = col_r + CW'(1);
        end
        state_nxt = fsd_pkg::S_OUT;
      end
      fsd_pkg::S_OUT: begin
        // The last column's entry is written here; repeating it while stalled is harmless.
        if (last_r) begin
          ram_we    = 1'b1;
          ram_waddr = col_r;
          ram_wdata = wlast_r;
        end
        if (!out_valid_r || out_pix.ready) begin
          out_valid_nxt = 1'b1;
          out_gray_nxt  = q_r;
          out_alpha_nxt = alpha_r;
          state_nxt     = fsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fsd_pkg::S_IDLE;
      end
    endcase

    // The divider operands are loaded on the way into the step loop.
    if (state_r == fsd_pkg::S_ACC) begin
      rem_nxt = '0;
      dsr_nxt = {lvl, 1'b0};
      dvd_nxt = '0;
    end

    // A taken beat empties the output register unless a new one is loaded.
    if (out_valid_r && out_pix.ready && !(state_r == fsd_pkg::S_OUT)) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= fsd_pkg::S_IDLE;
      column_index_r <= '0;
      on_first_row_r <= 1'b1;
      carry_r        <= '0;
      pend_cur_r     <= '0;
      pend_prev_r    <= '0;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
    end else begin
      state_r        <= state_nxt;
      column_index_r <= column_index_nxt;
      on_first_row_r <= on_first_row_nxt;
      carry_r        <= carry_nxt;
      pend_cur_r     <= pend_cur_nxt;
      pend_prev_r    <= pend_prev_nxt;
      out_valid_r    <= out_valid_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    gray_r      <= gray_nxt;
    alpha_r     <= alpha_nxt;
    acc_r       <= acc_nxt;
    dsr_r       <= dsr_nxt;
    quo_r       <= quo_nxt;
    q_r         <= q_nxt;
    err_r       <= err_nxt;
    wlast_r     <= wlast_nxt;
    out_gray_r  <= out_gray_nxt;
    out_alpha_r <= out_alpha_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.gray_out  = out_gray_r;
  assign out_pix.alpha_out = out_alpha_r;

  // An accepted beat always starts the error sum in the next cycle.
  a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (state_r == fsd_pkg::S_ACC))
    else $error("accepted pixel did not move to the error sum");

  // The quantizer loop runs exactly DIV_STEPS steps.
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsd_pkg::S_ACC) |=> ##(fsd_pkg::DIV_STEPS) (state_r == fsd_pkg::S_MUL))
    else $error("quantizer did not finish in the expected number of steps");

  // The division remainder is below the divisor once the last step is done.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsd_pkg::S_MUL) |-> (rem_r < dsr_r))
    else $error("division remainder reached the divisor");

  // The line store is written only while spreading error or delivering a result.
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == fsd_pkg::S_ERR || state_r == fsd_pkg::S_OUT))
    else $error("line store written outside the error phases");

  // Finishing the last column of a row wraps the column and leaves the first row.
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsd_pkg::S_ERR && last_r) |=> (column_index_r == '0 && !on_first_row_r))
    else $error("row end did not wrap the column index");

endmodule
